// ===== sv/bal_pkg.sv =====
// Package for the bounded array list: field widths, opcodes, status codes, FSM states.
package bal_pkg;

  // Default list depth
  localparam int CAPACITY_DEF = 64;

  // Fixed field widths of the request and result
  localparam int OPCODE_W = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 6;
  localparam int COUNT_W  = 7;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((POS_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STATUS_W + FOUND_W + COUNT_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_BAD_POS   = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_START,
    FSM_WALK,
    FSM_FINAL,
    FSM_DONE
  } fsm_state_t;

endpackage

// ===== sv/bounded_array_list_top.sv =====
// Bounded array list: an ordered list of signed 32-bit values held in one memory.
//
// Each request carries an opcode (insert, delete, find, clear), a position and a
// value, and produces exactly one result with a status, the first matching
// position of a find, and the entry count after the operation. The entries sit in
// a single-port-write, single-port-read memory with a registered read; insert
// and delete move the entries behind the position one slot per cycle, and find
// scans from the start one entry per cycle. The walk reads count - position
// entries for insert, count - position - 1 for delete, and position of the
// match + 1 or the full count for find. Clear, append, removal of the last
// entry and rejected requests skip the walk. The walk closes on the registered
// data of its last read, and an insert then writes the new value from
// FSM_FINAL. The next request is taken in the cycle after the result is loaded,
// and the result is loaded only while no earlier result waits on the receiver.
// One request is in flight at a time. The memory needs no clearing after reset:
// only entries below the count are ever read.
module bounded_array_list_top
  import bal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [6:0] position, [38:7] value, [39] zero
  input  logic [OPCODE_W-1:0]   s_axis_tuser,   // [1:0] opcode
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [2:0] status, [8:3] found_position,
                                                // [15:9] count
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

  // Control and request registers
  fsm_state_t                 state, state_next;
  opcode_t                    op;
  logic [POS_W-1:0]           pos;
  logic signed [VALUE_W-1:0]  val;
  logic [CNTW-1:0]            count, count_next;
  logic [AW-1:0]              rd_addr, rd_addr_next;
  logic                       issuing, issuing_next;
  logic                       pend;
  logic [AW-1:0]              pend_addr;
  status_t                    res_status, res_status_next;
  logic [FOUND_W-1:0]         res_found, res_found_next;

  // Memory
  logic signed [VALUE_W-1:0]  mem [CAPACITY];
  logic signed [VALUE_W-1:0]  rd_data;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic signed [VALUE_W-1:0]  mem_wdata;

  // Derived compares
  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic [AW-1:0]   pos_a, last_a;
  logic            is_full, last_rd, pend_end, hit, walk_done, out_free;

  assign pos_ext  = CMPW'(pos);
  assign cnt_ext  = CMPW'(count);
  assign pos_a    = AW'(pos);
  assign last_a   = AW'(count - CNTW'(1));
  assign is_full  = (count == CNTW'(CAPACITY));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Walk end detection: insert walks down to the position, the others up to the top
  assign last_rd   = (op == OP_INSERT) ? (rd_addr == pos_a) : (rd_addr == last_a);
  assign pend_end  = pend && ((op == OP_INSERT) ? (pend_addr == pos_a)
                                                : (pend_addr == last_a));
  assign hit       = pend && (op == OP_FIND) && (rd_data == val);
  assign walk_done = hit || pend_end;

  assign s_axis_tready = (state == FSM_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (s_axis_tvalid) state_next = FSM_START;
      end
      FSM_START: begin
        state_next = FSM_DONE;
        case (op)
          OP_INSERT: begin
            if (!is_full && pos_ext < cnt_ext) state_next = FSM_WALK;
          end
          OP_DELETE: begin
            if (pos_ext < cnt_ext && pos_a != last_a) state_next = FSM_WALK;
          end
          OP_FIND: begin
            if (count != '0) state_next = FSM_WALK;
          end
          default: state_next = FSM_DONE;
        endcase
      end
      FSM_WALK: begin
        if (walk_done) state_next = (op == OP_INSERT) ? FSM_FINAL : FSM_DONE;
      end
      FSM_FINAL: state_next = FSM_DONE;
      FSM_DONE: begin
        if (out_free) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // Datapath control and memory port
  always_comb begin
    count_next      = count;
    rd_addr_next    = rd_addr;
    issuing_next    = issuing;
    res_status_next = res_status;
    res_found_next  = res_found;
    mem_we          = 1'b0;
    mem_waddr       = pos_a;
    mem_wdata       = val;
    unique case (state)
      FSM_IDLE: ;
      FSM_START: begin
        res_status_next = STAT_OK;
        res_found_next  = '0;
        issuing_next    = 1'b0;
        case (op)
          OP_INSERT: begin
            if (is_full) begin
              res_status_next = STAT_FULL;
            end else if (pos_ext > cnt_ext) begin
              res_status_next = STAT_BAD_POS;
            end else if (pos_ext == cnt_ext) begin
              // append: no entries to move
              mem_we     = 1'b1;
              count_next = count + CNTW'(1);
            end else begin
              rd_addr_next = last_a;
              issuing_next = 1'b1;
            end
          end
          OP_DELETE: begin
            if (pos_ext >= cnt_ext) begin
              res_status_next = STAT_BAD_POS;
            end else if (pos_a == last_a) begin
              count_next = count - CNTW'(1);
            end else begin
              rd_addr_next = pos_a + AW'(1);
              issuing_next = 1'b1;
            end
          end
          OP_FIND: begin
            if (count == '0) begin
              res_status_next = STAT_EMPTY;
            end else begin
              rd_addr_next = '0;
              issuing_next = 1'b1;
            end
          end
          default: count_next = '0;
        endcase
      end
      FSM_WALK: begin
        // issue the next read
        if (issuing) begin
          if (last_rd) issuing_next = 1'b0;
          else if (op == OP_INSERT) rd_addr_next = rd_addr - AW'(1);
          else rd_addr_next = rd_addr + AW'(1);
        end
        // write back the entry read last cycle, one slot over
        if (pend && op != OP_FIND) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data;
          mem_waddr = (op == OP_INSERT) ? pend_addr + AW'(1) : pend_addr - AW'(1);
        end
        if (hit) begin
          res_found_next = FOUND_W'(pend_addr);
        end else if (pend_end) begin
          if (op == OP_FIND) res_status_next = STAT_NOT_FOUND;
          else if (op == OP_DELETE) count_next = count - CNTW'(1);
        end
      end
      FSM_FINAL: begin
        // drop the new value into the opened slot
        mem_we     = 1'b1;
        count_next = count + CNTW'(1);
      end
      FSM_DONE: ;
      default: ;
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FSM_IDLE;
      count         <= '0;
      issuing       <= 1'b0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      issuing <= issuing_next;
      pend    <= (state == FSM_WALK) && issuing;
      if (state == FSM_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == FSM_IDLE && s_axis_tvalid) begin
      op  <= opcode_t'(s_axis_tuser);
      pos <= s_axis_tdata[POS_W-1:0];
      val <= s_axis_tdata[POS_W +: VALUE_W];
    end
    rd_addr    <= rd_addr_next;
    pend_addr  <= rd_addr;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    if (state == FSM_DONE && out_free) begin
      m_axis_tdata <= OUT_DATA_W'({COUNT_W'(count), res_found, res_status});
    end
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  // The count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(CAPACITY))
    else $error("entry count above capacity");

  // Every memory write lands inside the list or one past its end
  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CNTW'(mem_waddr) <= count))
    else $error("memory write outside the list");

  // An accepted request leaves the count alone during its first cycle
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> $stable(count))
    else $error("count changed before request decode");

  // A walk write only follows a read issued the cycle before
  a_walk_write: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_WALK && mem_we) |-> ($past(issuing) && $past(state) == FSM_WALK))
    else $error("walk write without a pending read");

endmodule
